// ===== design/jsc_pkg.sv =====
// ----------------------------------------------------------------------------
// jsc_pkg: shared constants and types for the JPEG stream carver
// Marker byte codes, window geometry, length limits and inter-module structs.
// ----------------------------------------------------------------------------
package jsc_pkg;

    localparam int BLOCK_BYTES = 4096;
    localparam int WIN_DEPTH   = 9;
    localparam int LEN_W       = 24;
    localparam int BYTE_W      = 8;

    localparam logic [LEN_W-1:0] LEN_MAX    = {LEN_W{1'b1}};
    localparam logic [LEN_W-1:0] HEADER_LEN = LEN_W'(10);

    // 129 blocks: the header block plus 128 further ones
    localparam int                 MAX_LEN_RST_INT = 129 * BLOCK_BYTES;
    localparam logic [LEN_W-1:0]   MAX_LEN_RST     = LEN_W'(MAX_LEN_RST_INT);

    localparam logic [BYTE_W-1:0] MK_FF   = 8'hFF;
    localparam logic [BYTE_W-1:0] MK_SOI  = 8'hD8;
    localparam logic [BYTE_W-1:0] MK_APP0 = 8'hE0;
    localparam logic [BYTE_W-1:0] MK_APP1 = 8'hE1;
    localparam logic [BYTE_W-1:0] MK_EOI  = 8'hD9;
    localparam logic [BYTE_W-1:0] CH_UP_J = 8'h4A;
    localparam logic [BYTE_W-1:0] CH_UP_F = 8'h46;
    localparam logic [BYTE_W-1:0] CH_UP_I = 8'h49;
    localparam logic [BYTE_W-1:0] CH_UP_E = 8'h45;
    localparam logic [BYTE_W-1:0] CH_LO_X = 8'h78;
    localparam logic [BYTE_W-1:0] CH_LO_I = 8'h69;
    localparam logic [BYTE_W-1:0] CH_LO_F = 8'h66;

    typedef struct packed {
        logic header_ok;   // window plus new byte form a full header
        logic prev_ff;     // newest window byte is FF
    } match_t;

    typedef struct packed {
        logic             header_hit;
        logic             in_image;
        logic             end_hit;
        logic             gave_up;
        logic [LEN_W-1:0] image_length;
    } result_t;

endpackage

// ===== design/jsc_window.sv =====
// ----------------------------------------------------------------------------
// jsc_window: nine-byte history window and header pattern match
// Shifts one byte per step and flags FF D8 FF (E0|E1) xx xx JFIF/Exif.
// ----------------------------------------------------------------------------
module jsc_window
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step,
    input  logic [jsc_pkg::BYTE_W-1:0]   new_byte,
    output jsc_pkg::match_t              match
);

    logic [jsc_pkg::BYTE_W-1:0] win_reg [jsc_pkg::WIN_DEPTH];
    logic lead;
    logic jfif;
    logic exif;

    always_comb
    begin
        lead = (win_reg[0] == jsc_pkg::MK_FF) && (win_reg[1] == jsc_pkg::MK_SOI) &&
               (win_reg[2] == jsc_pkg::MK_FF) &&
               ((win_reg[3] == jsc_pkg::MK_APP0) || (win_reg[3] == jsc_pkg::MK_APP1));
        jfif = (win_reg[6] == jsc_pkg::CH_UP_J) && (win_reg[7] == jsc_pkg::CH_UP_F) &&
               (win_reg[8] == jsc_pkg::CH_UP_I) && (new_byte == jsc_pkg::CH_UP_F);
        exif = (win_reg[6] == jsc_pkg::CH_UP_E) && (win_reg[7] == jsc_pkg::CH_LO_X) &&
               (win_reg[8] == jsc_pkg::CH_LO_I) && (new_byte == jsc_pkg::CH_LO_F);
        match.header_ok = lead && (jfif || exif);
        match.prev_ff   = (win_reg[jsc_pkg::WIN_DEPTH-1] == jsc_pkg::MK_FF);
    end

    // oldest byte at index 0, newest at the top
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < jsc_pkg::WIN_DEPTH; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (step)
        begin
            for (int i = 0; i < jsc_pkg::WIN_DEPTH - 1; i++)
            begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[jsc_pkg::WIN_DEPTH-1] <= new_byte;
        end
    end

endmodule

// ===== design/jsc_tracker.sv =====
// ----------------------------------------------------------------------------
// jsc_tracker: search / carve mode and image length counter
// Produces the per-byte result word from the match flags and current mode.
// ----------------------------------------------------------------------------
module jsc_tracker
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  logic [jsc_pkg::BYTE_W-1:0]  new_byte,
    input  jsc_pkg::match_t             match,
    input  logic [jsc_pkg::LEN_W-1:0]   max_length,
    output jsc_pkg::result_t            res
);

    logic                       carving_reg;
    logic                       carving_next;
    logic [jsc_pkg::LEN_W-1:0]  length_reg;
    logic [jsc_pkg::LEN_W-1:0]  length_next;
    logic [jsc_pkg::LEN_W-1:0]  length_inc;

    always_comb
    begin
        // saturate at the top of the range
        length_inc   = (length_reg != jsc_pkg::LEN_MAX) ? length_reg + 1'b1 : length_reg;
        carving_next = carving_reg;
        length_next  = length_reg;
        res          = '0;
        if (carving_reg)
        begin
            length_next      = length_inc;
            res.in_image     = 1'b1;
            res.image_length = length_inc;
            if (match.prev_ff && (new_byte == jsc_pkg::MK_EOI))
            begin
                res.end_hit  = 1'b1;
                carving_next = 1'b0;
            end
            else if (length_inc >= max_length)
            begin
                res.gave_up  = 1'b1;
                carving_next = 1'b0;
            end
        end
        else if (match.header_ok)
        begin
            res.header_hit   = 1'b1;
            carving_next     = 1'b1;
            length_next      = jsc_pkg::HEADER_LEN;
            res.image_length = jsc_pkg::HEADER_LEN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carving_reg <= 1'b0;
            length_reg  <= '0;
        end
        else if (step)
        begin
            carving_reg <= carving_next;
            length_reg  <= length_next;
        end
    end

    a_hdr_starts_image: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.header_hit |=> carving_reg && (length_reg == jsc_pkg::HEADER_LEN))
        else $error("header hit did not enter carving with header length");

    a_end_leaves_image: assert property (@(posedge clk) disable iff (!rst_n)
        step && (res.end_hit || res.gave_up) |=> !carving_reg)
        else $error("carving continued after end or give-up");

    a_end_excl_giveup: assert property (@(posedge clk) disable iff (!rst_n)
        !(res.end_hit && res.gave_up))
        else $error("end marker and give-up raised together");

    a_hit_only_searching: assert property (@(posedge clk) disable iff (!rst_n)
        res.header_hit |-> !carving_reg && !res.in_image)
        else $error("header hit while carving");

endmodule

// ===== design/jpeg_stream_carver.sv =====
// ----------------------------------------------------------------------------
// jpeg_stream_carver: JPEG header / end marker carving over a raw byte stream
// Input register, single-pass match and length logic, result register.
// ----------------------------------------------------------------------------
// Order: the accepting edge loads a byte into the input register; after that,
// its result word is loaded into the result register.
// Throughput: 1 byte per cycle; input register and result register both
// advance each cycle the output is not stalled.
// Reset: window cleared, mode searching, length zero, max_length to 129
// blocks; no clearing pass, bytes accepted right after reset.
module jpeg_stream_carver
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [7:0]                  data_byte,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        header_hit,
    output logic                        in_image,
    output logic                        end_hit,
    output logic                        gave_up,
    output logic [23:0]                 image_length,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [23:0]                 cfg_data
);

    logic                        s1_valid_reg;
    logic [jsc_pkg::BYTE_W-1:0]  s1_byte_reg;
    logic                        out_valid_reg;
    jsc_pkg::result_t            out_reg;
    logic [jsc_pkg::LEN_W-1:0]   max_length_reg;
    logic                        out_free;
    logic                        step;
    jsc_pkg::match_t             match;
    jsc_pkg::result_t            res;

    assign out_free  = !out_valid_reg || !out_stall;
    assign step      = s1_valid_reg && out_free;
    assign in_stall  = s1_valid_reg && !out_free;
    assign cfg_ready = 1'b1;

    jsc_window u_window
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .new_byte (s1_byte_reg),
        .match    (match)
    );

    jsc_tracker u_tracker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .new_byte   (s1_byte_reg),
        .match      (match),
        .max_length (max_length_reg),
        .res        (res)
    );

    // input register: refill when empty or draining this cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_byte_reg <= data_byte;
        end
    end

    // result register: hold while stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_reg <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_length_reg <= jsc_pkg::MAX_LEN_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            max_length_reg <= cfg_data;
        end
    end

    assign out_valid    = out_valid_reg;
    assign header_hit   = out_reg.header_hit;
    assign in_image     = out_reg.in_image;
    assign end_hit      = out_reg.end_hit;
    assign gave_up      = out_reg.gave_up;
    assign image_length = out_reg.image_length;

endmodule
